// File: rtl/scms_pkg.sv
// Package: types, constants and command codes of the sparse column matrix store.
`timescale 1ns / 1ps
package scms_pkg;

	localparam int MAX_ROWS    = 1024;
	localparam int MAX_COLS    = 64;
	localparam int MAX_NZ      = 256;

	localparam int ROW_W       = 10;
	localparam int COL_W       = 6;
	localparam int VAL_W       = 32;
	localparam int PTR_W       = 9;	// column pointers and entry counts, 0..MAX_NZ
	localparam int NROWS_W     = 11;
	localparam int NCOLS_W     = 7;
	localparam int CADDR_W     = 7;	// pointer table address, 0..MAX_COLS
	localparam int EADDR_W     = 8;	// entry memory address
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

	localparam logic [NROWS_W-1:0] NUM_ROWS_RST = NROWS_W'(MAX_ROWS);
	localparam logic [NCOLS_W-1:0] NUM_COLS_RST = NCOLS_W'(MAX_COLS);

	typedef struct packed {
		logic                    operation;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] new_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [1:0]              status;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_PTR_RD_S,
		CMD_PTR_RD_E,
		CMD_SCAN_INIT,
		CMD_SCAN_RD,
		CMD_SCAN_CMP,
		CMD_UPDATE,
		CMD_DEL_INIT,
		CMD_DEL_RD,
		CMD_DEL_WR,
		CMD_DEL_END,
		CMD_INS_INIT,
		CMD_INS_RD,
		CMD_INS_WR,
		CMD_INS_PUT,
		CMD_ADJ_RD,
		CMD_ADJ_WR,
		CMD_FULL,
		CMD_FINISH
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic range_err;
		logic is_read;
		logic nv_zero;
		logic found;
		logic full;
		logic scan_more;
		logic scan_stop;
		logic del_more;
		logic ins_more;
		logic adj_more;
	} dp_status_t;

endpackage

// File: rtl/scms_ctrl.sv
// Controller state machine of the sparse column matrix store.
`timescale 1ns / 1ps
module scms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  scms_pkg::dp_status_t st,
	output scms_pkg::cmd_t      cmd
);
	import scms_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_PTR_E,
		S_SCAN_INIT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_DEL_RD,
		S_DEL_WR,
		S_INS_RD,
		S_INS_WR,
		S_ADJ_RD,
		S_ADJ_WR,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	// Choose the command and the next state
	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd     = CMD_PTR_RD_S;
				state_d = st.range_err ? S_DONE : S_PTR_E;
			end
			S_PTR_E: begin
				cmd     = CMD_PTR_RD_E;
				state_d = S_SCAN_INIT;
			end
			S_SCAN_INIT: begin
				cmd     = CMD_SCAN_INIT;
				state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd     = CMD_SCAN_RD;
				state_d = st.scan_more ? S_SCAN_CMP : S_DECIDE;
			end
			S_SCAN_CMP: begin
				cmd     = CMD_SCAN_CMP;
				state_d = st.scan_stop ? S_DECIDE : S_SCAN_RD;
			end
			S_DECIDE: begin
				state_d = S_DONE;
				if (!st.is_read) begin
					if (st.found) begin
						if (st.nv_zero) begin
							cmd     = CMD_DEL_INIT;
							state_d = S_DEL_RD;
						end else begin
							cmd = CMD_UPDATE;
						end
					end else if (!st.nv_zero) begin
						if (st.full) begin
							cmd = CMD_FULL;
						end else begin
							cmd     = CMD_INS_INIT;
							state_d = S_INS_RD;
						end
					end
				end
			end
			S_DEL_RD: begin
				if (st.del_more) begin
					cmd     = CMD_DEL_RD;
					state_d = S_DEL_WR;
				end else begin
					cmd     = CMD_DEL_END;
					state_d = S_ADJ_RD;
				end
			end
			S_DEL_WR: begin
				cmd     = CMD_DEL_WR;
				state_d = S_DEL_RD;
			end
			S_INS_RD: begin
				if (st.ins_more) begin
					cmd     = CMD_INS_RD;
					state_d = S_INS_WR;
				end else begin
					cmd     = CMD_INS_PUT;
					state_d = S_ADJ_RD;
				end
			end
			S_INS_WR: begin
				cmd     = CMD_INS_WR;
				state_d = S_INS_RD;
			end
			S_ADJ_RD: begin
				if (st.adj_more) begin
					cmd     = CMD_ADJ_RD;
					state_d = S_ADJ_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_ADJ_WR: begin
				cmd     = CMD_ADJ_WR;
				state_d = S_ADJ_RD;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd     = CMD_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == CMD_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/scms_dp.sv
// Datapath of the sparse column matrix store: registers, pointer table and entry memory.
`timescale 1ns / 1ps
module scms_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [scms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [scms_pkg::CFG_W-1:0]     cfg_data,
	input  scms_pkg::in_item_t            in_data,
	output scms_pkg::out_item_t           out_data,
	input  scms_pkg::cmd_t                cmd,
	output scms_pkg::dp_status_t          st,
	output logic [scms_pkg::PTR_W-1:0]    count
);
	import scms_pkg::*;

	localparam int ENT_W = ROW_W + VAL_W;
	localparam int CDEPTH = MAX_COLS + 1;

	logic [NROWS_W-1:0]  num_rows_q;
	logic [NCOLS_W-1:0]  num_cols_q;
	logic [PTR_W-1:0]    count_q;
	logic [CDEPTH-1:0]   ptr_vld_q;
	logic [PTR_W-1:0]    ptr_mem [CDEPTH];
	logic [PTR_W-1:0]    ptr_rd_q;
	logic [ENT_W-1:0]    ent_mem [MAX_NZ];
	logic [ENT_W-1:0]    ent_rd_q;

	in_item_t            req_q;
	out_item_t           out_q;
	logic [PTR_W-1:0]    s_q;
	logic [PTR_W-1:0]    e_q;
	logic [PTR_W-1:0]    k_q;
	logic [PTR_W-1:0]    pos_q;
	logic [CADDR_W-1:0]  c_q;
	logic                found_q;
	logic                full_q;
	logic                ins_q;
	logic [VAL_W-1:0]    val_q;

	logic [CADDR_W-1:0]  ptr_raddr;
	logic                ptr_we;
	logic [PTR_W-1:0]    ptr_adj;
	logic [EADDR_W-1:0]  ent_raddr;
	logic                ent_we;
	logic [EADDR_W-1:0]  ent_waddr;
	logic [ENT_W-1:0]    ent_wdata;
	logic [ROW_W-1:0]    ent_row;
	logic                range_err;
	logic                hit;
	logic                greater;
	logic [PTR_W-1:0]    s_clamp;
	logic [PTR_W-1:0]    e_clamp;
	logic [PTR_W-1:0]    e_lim;

	assign out_data = out_q;
	assign count    = count_q;
	assign ent_row  = ent_rd_q[ENT_W-1 -: ROW_W];

	// Range check against the registers in use
	assign range_err = ({1'b0, req_q.row} >= num_rows_q) || ({1'b0, req_q.col} >= num_cols_q);

	// Scan compare on the entry just read
	assign hit     = (ent_row == req_q.row);
	assign greater = (ent_row > req_q.row);

	// Clamp the column bounds to the store size and the live count
	assign s_clamp = (s_q > PTR_W'(MAX_NZ)) ? PTR_W'(MAX_NZ) : s_q;
	assign e_clamp = (ptr_rd_q > PTR_W'(MAX_NZ)) ? PTR_W'(MAX_NZ) : ptr_rd_q;
	assign e_lim   = (e_clamp > count_q) ? count_q : e_clamp;

	// Raise or lower one column pointer
	always_comb begin
		if (ins_q) begin
			ptr_adj = (ptr_rd_q >= PTR_W'(MAX_NZ)) ? PTR_W'(MAX_NZ) : ptr_rd_q + 1'b1;
		end else begin
			ptr_adj = (ptr_rd_q != '0) ? ptr_rd_q - 1'b1 : ptr_rd_q;
		end
	end

	// Status toward the controller
	always_comb begin
		st.range_err = range_err;
		st.is_read   = !req_q.operation;
		st.nv_zero   = (req_q.new_value == '0);
		st.found     = found_q;
		st.full      = (count_q >= PTR_W'(MAX_NZ));
		st.scan_more = (k_q < e_q);
		st.scan_stop = hit || greater;
		st.del_more  = ({1'b0, k_q} + 1'b1) < {1'b0, count_q};
		st.ins_more  = (k_q > pos_q);
		st.adj_more  = (c_q <= CADDR_W'(MAX_COLS));
	end

	// Select memory addresses and write data
	always_comb begin
		ptr_raddr = {1'b0, req_q.col};
		ptr_we    = 1'b0;
		ent_raddr = k_q[EADDR_W-1:0];
		ent_we    = 1'b0;
		ent_waddr = k_q[EADDR_W-1:0];
		ent_wdata = ent_rd_q;
		case (cmd)
			CMD_PTR_RD_E: begin
				ptr_raddr = {1'b0, req_q.col} + 1'b1;
			end
			CMD_ADJ_RD: begin
				ptr_raddr = c_q;
			end
			CMD_ADJ_WR: begin
				ptr_we = 1'b1;
			end
			CMD_DEL_RD: begin
				ent_raddr = k_q[EADDR_W-1:0] + 1'b1;
			end
			CMD_INS_RD: begin
				ent_raddr = k_q[EADDR_W-1:0] - 1'b1;
			end
			CMD_DEL_WR, CMD_INS_WR: begin
				ent_we = 1'b1;
			end
			CMD_UPDATE, CMD_INS_PUT: begin
				ent_we    = 1'b1;
				ent_waddr = pos_q[EADDR_W-1:0];
				ent_wdata = {req_q.row, req_q.new_value};
			end
			default: begin
				ent_we = 1'b0;
			end
		endcase
	end

	// Pointer table and entry memory
	always_ff @(posedge clk) begin
		ptr_rd_q <= ptr_vld_q[ptr_raddr] ? ptr_mem[ptr_raddr] : '0;
		if (ptr_we) begin
			ptr_mem[c_q] <= ptr_adj;
		end
		ent_rd_q <= ent_mem[ent_raddr];
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
	end

	// Hold registers, entry count and pointer valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= NUM_ROWS_RST;
			num_cols_q <= NUM_COLS_RST;
			count_q    <= '0;
			ptr_vld_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_ROWS: num_rows_q <= cfg_data;
					REG_NUM_COLS: num_cols_q <= cfg_data[NCOLS_W-1:0];
					default:      num_rows_q <= num_rows_q;
				endcase
			end
			if (ptr_we) begin
				ptr_vld_q[c_q] <= 1'b1;
			end
			if (cmd == CMD_DEL_END) begin
				count_q <= count_q - 1'b1;
			end else if (cmd == CMD_INS_PUT) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Advance the per-item working registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				req_q   <= in_data;
				found_q <= 1'b0;
				full_q  <= 1'b0;
			end
			CMD_PTR_RD_E: begin
				s_q <= ptr_rd_q;
			end
			CMD_SCAN_INIT: begin
				k_q   <= s_clamp;
				e_q   <= e_lim;
				pos_q <= e_lim;
			end
			CMD_SCAN_CMP: begin
				if (hit) begin
					found_q <= 1'b1;
					pos_q   <= k_q;
					val_q   <= ent_rd_q[VAL_W-1:0];
				end else if (greater) begin
					pos_q <= k_q;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			CMD_DEL_INIT: begin
				k_q <= pos_q;
			end
			CMD_DEL_WR: begin
				k_q <= k_q + 1'b1;
			end
			CMD_DEL_END: begin
				c_q   <= {1'b0, req_q.col} + 1'b1;
				ins_q <= 1'b0;
			end
			CMD_INS_INIT: begin
				k_q <= count_q;
			end
			CMD_INS_WR: begin
				k_q <= k_q - 1'b1;
			end
			CMD_INS_PUT: begin
				c_q   <= {1'b0, req_q.col} + 1'b1;
				ins_q <= 1'b1;
			end
			CMD_ADJ_WR: begin
				c_q <= c_q + 1'b1;
			end
			CMD_FULL: begin
				full_q <= 1'b1;
			end
			CMD_FINISH: begin
				out_q.result_value <= found_q ? val_q : '0;
				out_q.status       <= range_err ? ST_RANGE : (full_q ? ST_FULL : ST_OK);
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

endmodule

// File: rtl/sparse_column_matrix_store.sv
// An out-of-range item goes straight to its result; a read scans the entries of its column.
// An insert or a removal also shifts the entries behind its position and raises or lowers every
// later column pointer; each step waits on the registered read of the entry memory or table.
// One item at a time: the next item is accepted the cycle after the result is loaded into the
// output register. Reset clears the entry count, the pointer valid bits and the handshake;
// registers return to 1024 rows and 64 columns.
`timescale 1ns / 1ps
module sparse_column_matrix_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [scms_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  scms_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output scms_pkg::out_item_t            out_data
);
	import scms_pkg::*;

	cmd_t             cmd;
	dp_status_t       st;
	logic [PTR_W-1:0] count;

	scms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	scms_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.st        (st),
		.count     (count)
	);

	// Entry count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= PTR_W'(MAX_NZ))
		else $error("entry count above store size");

	// An accepted item blocks the input until its result is out
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	// Out-of-range and full results carry a zero value
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_RANGE || out_data.status == ST_FULL)
			|-> out_data.result_value == '0)
		else $error("error result with nonzero value");

endmodule

// File: dv/sparse_column_matrix_store_test.sv
// Testbench: directed and random traffic into the sparse column matrix store with a predictor.
`timescale 1ns / 1ps
module sparse_column_matrix_store_test;
	import scms_pkg::*;

	// Predictor of the matrix contents and the expected result items
	class csc_scoreboard;
		int unsigned rows_cfg;
		int unsigned cols_cfg;
		int unsigned ptr [MAX_COLS+1];
		logic [ROW_W-1:0] rix [MAX_NZ];
		logic [VAL_W-1:0] val [MAX_NZ];
		int unsigned count;
		out_item_t pending [$];
		int errors;

		function new();
			rows_cfg = MAX_ROWS;
			cols_cfg = MAX_COLS;
			count = 0;
			errors = 0;
			foreach (ptr[i]) ptr[i] = 0;
		endfunction

		function void shift_ptrs(int unsigned c, bit up);
			for (int unsigned j = c + 1; j <= MAX_COLS; j++) begin
				if (up) ptr[j] = (ptr[j] + 1 > MAX_NZ) ? MAX_NZ : ptr[j] + 1;
				else if (ptr[j] > 0) ptr[j] = ptr[j] - 1;
			end
		endfunction

		// Apply one accepted request and queue the item it should produce
		function void note_request(in_item_t it);
			out_item_t res;
			int unsigned rl, cl, s, e, pos;
			bit hit;
			res.result_value = '0;
			res.status = ST_OK;
			rl = rows_cfg > MAX_ROWS ? MAX_ROWS : rows_cfg;
			cl = cols_cfg > MAX_COLS ? MAX_COLS : cols_cfg;
			hit = 0;
			if (it.row >= rl || it.col >= cl) begin
				res.status = ST_RANGE;
				pending.push_back(res);
				return;
			end
			s = ptr[it.col] > MAX_NZ ? MAX_NZ : ptr[it.col];
			e = ptr[it.col+1] > MAX_NZ ? MAX_NZ : ptr[it.col+1];
			if (e > count) e = count;
			pos = e;
			for (int unsigned k = s; k < e; k++) begin
				if (rix[k] == it.row) begin
					hit = 1; pos = k; break;
				end
				if (rix[k] > it.row) begin
					pos = k; break;
				end
			end
			if (hit) res.result_value = val[pos];
			if (it.operation == 1'b1) begin
				if (hit) begin
					if (it.new_value != 0) val[pos] = it.new_value;
					else begin
						for (int unsigned k = pos; k + 1 < count; k++) begin
							rix[k] = rix[k+1];
							val[k] = val[k+1];
						end
						count--;
						shift_ptrs(it.col, 0);
					end
				end else if (it.new_value != 0) begin
					if (count >= MAX_NZ) res.status = ST_FULL;
					else begin
						for (int unsigned k = count; k > pos; k--) begin
							rix[k] = rix[k-1];
							val[k] = val[k-1];
						end
						rix[pos] = it.row;
						val[pos] = it.new_value;
						count++;
						shift_ptrs(it.col, 1);
					end
				end
			end
			pending.push_back(res);
		endfunction

		// Compare one result item with the oldest expectation
		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result item: value %0d status %0d",
					got.result_value, got.status);
				return;
			end
			want = pending.pop_front();
			if (got.result_value !== want.result_value || got.status !== want.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected value %0d status %0d, got value %0d status %0d",
						want.result_value, want.status, got.result_value, got.status);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	in_item_t in_data;
	out_item_t out_data;

	csc_scoreboard board;
	bit hold_off;
	bit stall_on;
	int hold_cycles;

	sparse_column_matrix_store dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("sparse_column_matrix_store_test: done, errors");
		$finish;
	end

	// Check result items and drive the receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(out_data);
		if (hold_off) out_stall <= 1'b1;
		else if (stall_on) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= 1'b0;
	end

	// Long receiver hold-off, counted in cycles
	initial begin
		hold_off = 0;
		wait (hold_cycles > 0);
		hold_off = 1;
		repeat (hold_cycles) @(posedge clk);
		hold_off = 0;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NUM_ROWS) board.rows_cfg = v & 'h7FF;
		else board.cols_cfg = v & 'h7F;
		@(posedge clk);
	endtask

	// Offer one item and hold it until accepted
	task automatic send_item(bit op, int unsigned r, int unsigned c, logic [31:0] v);
		in_item_t it;
		it.operation = op;
		it.row = ROW_W'(r);
		it.col = COL_W'(c);
		it.new_value = v;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		board.note_request(it);
	endtask

	task automatic idle_in(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		int guard;
		idle_in(1);
		guard = 0;
		while (board.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (1100) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Random burst: mostly writes into a small window so entries collide
	task automatic random_phase(int n, int rmax, int cmax, int zero_pct);
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			logic [31:0] v;
			if (burst == 0) begin
				if ($urandom_range(0, 2) == 0) idle_in($urandom_range(1, 12));
				burst = $urandom_range(1, 20);
			end
			burst--;
			v = ($urandom_range(0, 99) < zero_pct) ? 32'h0 : rand_value();
			if ($urandom_range(0, 9) == 0)
				send_item($urandom_range(0, 1) == 1, $urandom_range(0, 1023),
					$urandom_range(0, 63), v);
			else
				send_item($urandom_range(0, 2) != 0, $urandom_range(0, rmax),
					$urandom_range(0, cmax), v);
		end
	endtask

	initial begin
		board = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		in_data = '0;
		stall_on = 0;
		hold_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, in place update, insert, remove, absent zero, range errors
		send_item(0, 0, 0, 32'h1234);
		send_item(1, 0, 0, 32'h7FFF_FFFF);
		send_item(1, 1023, 63, 32'h8000_0000);
		send_item(1, 5, 0, 32'hFFFF_FFFF);
		send_item(1, 2, 0, 32'd7);
		send_item(0, 5, 0, 32'h0);
		send_item(1, 0, 0, 32'd9);
		send_item(1, 2, 0, 32'h0);
		send_item(1, 3, 0, 32'h0);
		send_item(0, 1023, 63, 32'hFFFF_FFFF);
		send_item(1, 512, 32, 32'h5555_AAAA);
		send_item(0, 512, 32, 32'h0);
		send_item(1, 1023, 63, 32'h0);
		drain();
		write_reg(REG_NUM_ROWS, 1);
		write_reg(REG_NUM_COLS, 1);
		send_item(0, 0, 0, 32'h0);
		send_item(0, 1, 0, 32'h0);
		send_item(1, 0, 1, 32'd3);
		drain();
		write_reg(REG_NUM_ROWS, 0);
		write_reg(REG_NUM_COLS, 127);
		send_item(0, 0, 0, 32'h0);
		drain();
		write_reg(REG_NUM_ROWS, 2047);
		write_reg(REG_NUM_COLS, 0);
		send_item(1, 0, 0, 32'd1);
		drain();

		// Random with full config, receiver stalling
		write_reg(REG_NUM_ROWS, 1024);
		write_reg(REG_NUM_COLS, 64);
		stall_on = 1;
		random_phase(40, 15, 7, 25);
		drain();

		// Fill the store to capacity, then exercise the full case
		stall_on = 0;
		for (int i = 0; i < 256; i++)
			send_item(1, 16 + (i % 64) * 4 + i / 64, i % 64, 32'd100 + i);
		send_item(1, 1000, 3, 32'd1);
		send_item(1, 1001, 63, 32'h8000_0000);
		send_item(1, 17, 1, 32'h0);
		send_item(1, 1001, 0, 32'd5);
		send_item(1, 1002, 0, 32'd6);
		drain();

		// Smaller window of rows and columns; long receiver hold-off during traffic
		write_reg(REG_NUM_ROWS, 300);
		write_reg(REG_NUM_COLS, 40);
		stall_on = 1;
		hold_cycles = 3000;
		random_phase(70, 350, 45, 60);
		drain();

		write_reg(REG_NUM_ROWS, 1024);
		write_reg(REG_NUM_COLS, 64);
		random_phase(60, 40, 12, 40);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("sparse_column_matrix_store_test: done, clean");
		else
			$display("sparse_column_matrix_store_test: done, errors");
		$finish;
	end
endmodule

// File: files.f
rtl/scms_pkg.sv
rtl/scms_ctrl.sv
rtl/scms_dp.sv
rtl/sparse_column_matrix_store.sv
dv/sparse_column_matrix_store_test.sv
